>>> src/ultrasonic_echo_ranger_defines.svh
// Assertion macros used by the checker file of the echo ranger.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Same-cycle implication, checked at each rising edge outside reset.
`define UER_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at each rising edge outside reset.
`define UER_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/uer_pkg.sv
// Shared types and constants of the ultrasonic echo ranger.
`default_nettype none

package uer_pkg;

   // Configuration register indexes.
   localparam logic [1:0] REG_TRIG_LOW  = 2'd0;
   localparam logic [1:0] REG_TRIG_HIGH = 2'd1;
   localparam logic [1:0] REG_TIMEOUT   = 2'd2;
   localparam logic [1:0] REG_TICKS_CM  = 2'd3;

   // Restoring divider: one quotient bit per cycle over a 16-bit echo time.
   localparam int DIV_STEPS    = 16;
   localparam int DIV_CNT_BITS = 4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic step;       // apply one item to the ranging state
      logic div_load;   // load the divider with the finished echo time
      logic div_step;   // one divider iteration
      logic out_load;   // load the result registers
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic finish;     // the item being applied completes a measurement
      logic div_last;   // the divider is on its final iteration
   } status_type;

endpackage

`default_nettype wire

>>> src/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: trigger pulse and echo timer.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_start_req, req_echo
//   rsp     | out       | rsp_valid / rsp_ready | trig, busy_res, done_res, echo_us, dist_cm
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// An accepted item passes through the push state into the result register, which it
// enters once that register is free. The item that completes a measurement first runs
// the restoring divider and then passes through the push state into the result register.
// The next item is taken once the previous result sits in the output register.
// A stalled rsp side holds further results back; reset is synchronous, active high.
// Configuration writes are always taken.
`default_nettype none

module ultrasonic_echo_ranger #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_start_req,
   input  wire logic        req_echo,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_trig,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic [15:0]      rsp_echo_us,
   output logic [15:0]      rsp_dist_cm,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   uer_pkg::cmd_type    cmd;
   uer_pkg::status_type status;

   assign csr_ready = 1'b1;

   uer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   uer_dp #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_start_req   (req_start_req),
      .req_echo        (req_echo),
      .cmd             (cmd),
      .status          (status),
      .rsp_trig        (rsp_trig),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_echo_us     (rsp_echo_us),
      .rsp_dist_cm     (rsp_dist_cm)
   );

endmodule

`default_nettype wire

>>> src/uer_ctrl.sv
// Cycle controller of the echo ranger: handshakes and divider sequencing.
`default_nettype none

module uer_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire uer_pkg::status_type status,
   output uer_pkg::cmd_type        cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   // The result register can take a new item when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.step     = 1'b1;
               cmd.div_load = status.finish;
               state_in     = status.finish ? ST_DIV : ST_PUSH;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> src/uer_dp.sv
// Datapath of the echo ranger: settings, ranging state, divider and result registers.
`default_nettype none

module uer_dp #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   input  wire logic [1:0]          csr_index,
   input  wire logic [15:0]         csr_wdata,
   input  wire logic                req_start_req,
   input  wire logic                req_echo,
   input  wire uer_pkg::cmd_type    cmd,
   output uer_pkg::status_type      status,
   output logic                     rsp_trig,
   output logic                     rsp_busy_res,
   output logic                     rsp_done_res,
   output logic [15:0]              rsp_echo_us,
   output logic [15:0]              rsp_dist_cm
);

   // Compare width: wide enough for the echo count and for timeout plus one.
   localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 17;
   localparam logic [COUNT_BITS-1:0] EC_MAX = {COUNT_BITS{1'b1}};

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_LOW  = 3'd1;
   localparam logic [2:0] PH_HIGH = 3'd2;
   localparam logic [2:0] PH_WAIT = 3'd3;
   localparam logic [2:0] PH_MEAS = 3'd4;

   logic [7:0]  low_ff;
   logic [7:0]  high_ff;
   logic [15:0] timeout_ff;
   logic [7:0]  tpc_ff;

   logic [2:0]            ph_ff;
   logic [2:0]            ph_in;
   logic [16:0]           cnt_ff;
   logic [16:0]           cnt_in;
   logic [COUNT_BITS-1:0] ec_ff;
   logic [COUNT_BITS-1:0] ec_in;
   logic [COUNT_BITS-1:0] ec_inc;
   logic                  trig_ff;
   logic                  trig_in;
   logic                  done_ff;
   logic [15:0]           last_echo_ff;

   logic [7:0]  high_len;
   logic        fin;
   logic [CW-1:0] fin_ticks;
   logic [15:0] fin_echo;

   logic [15:0] dist_ff;
   logic [15:0] dist_in;
   logic [7:0]  rem_ff;
   logic [7:0]  rem_in;
   logic [uer_pkg::DIV_CNT_BITS-1:0] div_cnt_ff;
   logic [8:0]  shifted;
   logic        ge;

   logic        out_trig_ff;
   logic        out_busy_ff;
   logic        out_done_ff;
   logic [15:0] out_echo_ff;
   logic [15:0] out_dist_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff     <= 8'd2;
         high_ff    <= 8'd10;
         timeout_ff <= 16'd60000;
         tpc_ff     <= 8'd58;
      end else if (csr_valid) begin
         case (csr_index)
            uer_pkg::REG_TRIG_LOW:  low_ff     <= csr_wdata[7:0];
            uer_pkg::REG_TRIG_HIGH: high_ff    <= csr_wdata[7:0];
            uer_pkg::REG_TIMEOUT:   timeout_ff <= csr_wdata;
            uer_pkg::REG_TICKS_CM:  tpc_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // A zero high length still gives one high tick.
   assign high_len = (high_ff == 8'd0) ? 8'd1 : high_ff;

   // Ranging phase update for one item.
   always_comb begin
      ph_in     = ph_ff;
      cnt_in    = cnt_ff;
      ec_in     = ec_ff;
      trig_in   = trig_ff;
      fin       = 1'b0;
      fin_ticks = '0;
      ec_inc    = (ec_ff != EC_MAX) ? ec_ff + 1'b1 : ec_ff;
      case (ph_ff)
         PH_IDLE: begin
            if (req_start_req) begin
               cnt_in = 17'd1;
               if (low_ff == 8'd0) begin
                  ph_in   = PH_HIGH;
                  trig_in = 1'b1;
               end else begin
                  ph_in   = PH_LOW;
                  trig_in = 1'b0;
               end
            end
         end
         PH_LOW: begin
            if (cnt_ff >= {9'd0, low_ff}) begin
               ph_in   = PH_HIGH;
               cnt_in  = 17'd1;
               trig_in = 1'b1;
            end else begin
               cnt_in  = cnt_ff + 17'd1;
               trig_in = 1'b0;
            end
         end
         PH_HIGH: begin
            if (cnt_ff >= {9'd0, high_len}) begin
               ph_in   = PH_WAIT;
               cnt_in  = 17'd0;
               trig_in = 1'b0;
            end else begin
               cnt_in  = cnt_ff + 17'd1;
               trig_in = 1'b1;
            end
         end
         PH_WAIT: begin
            trig_in = 1'b0;
            if (req_echo) begin
               ph_in = PH_MEAS;
               ec_in = '0;
            end else begin
               cnt_in = cnt_ff + 17'd1;
               // The wait gives up once it passes the timeout.
               if (cnt_in > {1'b0, timeout_ff}) begin
                  fin = 1'b1;
               end
            end
         end
         PH_MEAS: begin
            trig_in = 1'b0;
            if (req_echo) begin
               ec_in = ec_inc;
               if ((CW'(ec_inc) > CW'(timeout_ff)) || (ec_inc == EC_MAX)) begin
                  fin       = 1'b1;
                  fin_ticks = CW'(ec_inc);
               end
            end else begin
               fin       = 1'b1;
               fin_ticks = CW'(ec_ff);
            end
         end
         default: begin
            ph_in   = PH_IDLE;
            cnt_in  = 17'd0;
            trig_in = 1'b0;
         end
      endcase
      if (fin) begin
         ph_in   = PH_IDLE;
         cnt_in  = 17'd0;
         ec_in   = '0;
         trig_in = 1'b0;
      end
   end

   // Reported echo time saturates at the 16-bit limit.
   assign fin_echo      = (fin_ticks > CW'(16'hFFFF)) ? 16'hFFFF : fin_ticks[15:0];
   assign status.finish = fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff        <= PH_IDLE;
         cnt_ff       <= 17'd0;
         ec_ff        <= '0;
         trig_ff      <= 1'b0;
         done_ff      <= 1'b0;
         last_echo_ff <= 16'd0;
      end else if (cmd.step) begin
         ph_ff   <= ph_in;
         cnt_ff  <= cnt_in;
         ec_ff   <= ec_in;
         trig_ff <= trig_in;
         done_ff <= fin;
         if (fin) begin
            last_echo_ff <= fin_echo;
         end
      end
   end

   // Restoring divider. The quotient register doubles as the last distance.
   // A zero divisor gives an all-ones quotient, which is the required 65535.
   assign shifted = {rem_ff, dist_ff[15]};
   assign ge      = (shifted >= {1'b0, tpc_ff});
   assign rem_in  = ge ? 8'(shifted - {1'b0, tpc_ff}) : shifted[7:0];
   assign dist_in = {dist_ff[14:0], ge};
   assign status.div_last =
      (div_cnt_ff == uer_pkg::DIV_CNT_BITS'(uer_pkg::DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff    <= 16'd0;
         rem_ff     <= 8'd0;
         div_cnt_ff <= '0;
      end else if (cmd.div_load) begin
         dist_ff    <= fin_echo;
         rem_ff     <= 8'd0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         dist_ff    <= dist_in;
         rem_ff     <= rem_in;
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_trig_ff <= trig_ff;
         out_busy_ff <= (ph_ff != PH_IDLE);
         out_done_ff <= done_ff;
         out_echo_ff <= last_echo_ff;
         out_dist_ff <= dist_ff;
      end
   end

   assign rsp_trig     = out_trig_ff;
   assign rsp_busy_res = out_busy_ff;
   assign rsp_done_res = out_done_ff;
   assign rsp_echo_us  = out_echo_ff;
   assign rsp_dist_cm  = out_dist_ff;

endmodule

`default_nettype wire

>>> src/uer_checker.sv
// Port-level checker of the echo ranger and its bind to the top level.
`default_nettype none
`include "ultrasonic_echo_ranger_defines.svh"

module uer_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_trig,
   input wire logic        rsp_busy_res,
   input wire logic        rsp_done_res,
   input wire logic [15:0] rsp_echo_us,
   input wire logic [15:0] rsp_dist_cm
);

   // A stalled result item holds its payload.
   `UER_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_echo_us) && $stable(rsp_dist_cm), "stalled result item changed")

   // A completing item always reports the block as no longer busy.
   `UER_ASSERT_NOW(a_done_not_busy, clock, reset, rsp_valid && rsp_done_res,
      !rsp_busy_res, "done item reported busy")

   // With no sequence in progress the trigger is low.
   `UER_ASSERT_NOW(a_idle_trig_low, clock, reset, rsp_valid && !rsp_busy_res,
      !rsp_trig, "trigger high while idle")

   // After an item is taken the block works on it before taking another.
   `UER_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready,
      !req_ready, "input taken on consecutive cycles")

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);

`default_nettype wire
